// ===== hw/rtl/iptcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iptcf_pkg
// shared constants and types of the in-place transpose unit
// ----------------------------------------------------------------------------
package iptcf_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int DATA_WIDTH_DEF   = 32;

    localparam int REG_W   = 11;   // row_count / col_count
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 2;
    localparam int SIZE_W  = 2 * REG_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_READ      = 2'd1,
        FUNC_TRANSPOSE = 2'd2,
        FUNC_NOP       = 2'd3
    } t_func;

    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_SCAN,
        ST_TEST,
        ST_MUL,
        ST_MOD,
        ST_STEP,
        ST_SWAP
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/in_place_transpose_cycle_follow_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// in_place_transpose_cycle_follow_unit
// element store with in-place transpose by cycle following
// ----------------------------------------------------------------------------
// write / read / nop: result registered and offered on the next cycle after the transaction
// throughput: one write or read per cycle while idle and the result side accepts
// transpose: a check, clearing of the visited map, a scan and test per start, and per walk
//   step a multiply, a bit-serial modulo and a step state, plus a swap if still open
// reset: synchronous active low; clears control, row/col registers to 1
// the store holds unknown data until written; visited map is cleared per transpose
module in_place_transpose_cycle_follow_unit #(
    parameter int MAX_ELEMENTS = iptcf_pkg::MAX_ELEMENTS_DEF,
    parameter int DATA_WIDTH   = iptcf_pkg::DATA_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_addr,
    input  wire logic [10:0] i_cfg_data,
    // command stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // [9:0] index, [41:10] value, zero pad
    input  wire logic [1:0]  i_s_tuser,   // [1:0] func
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] read_value
    output logic [0:0]       o_m_tuser    // [0] size_error
);

    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam int REG_W  = iptcf_pkg::REG_W;
    localparam int SIZE_W = iptcf_pkg::SIZE_W;
    localparam int PW     = REG_W + AW;          // product rows * position
    localparam int CW     = $clog2(PW);

    // configuration registers
    logic [REG_W-1:0] r_rows;
    logic [REG_W-1:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= REG_W'(1);
            r_cols <= REG_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (iptcf_pkg::t_reg_idx'(i_cfg_addr))
                iptcf_pkg::REG_ROW_COUNT: r_rows <= i_cfg_data;
                iptcf_pkg::REG_COL_COUNT: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input unpacking
    iptcf_pkg::t_func  in_func;
    logic [31:0]       in_idx32;
    logic [31:0]       in_value;
    logic              in_range;
    logic [AW-1:0]     in_addr;
    logic [63:0]       in_value64;
    logic              s_accept;

    assign in_func    = iptcf_pkg::t_func'(i_s_tuser);
    assign in_idx32   = 32'(i_s_tdata[9:0]);
    assign in_value   = i_s_tdata[41:10];
    assign in_range   = in_idx32 < 32'(MAX_ELEMENTS);
    assign in_addr    = in_idx32[AW-1:0];
    assign in_value64 = 64'(in_value);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // store and visited map, one write and one registered read each per cycle
    logic [DATA_WIDTH-1:0] r_mem [MAX_ELEMENTS];
    logic                  r_vis [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0] r_mem_q;
    logic                  r_vis_q;

    logic                  mem_we, mem_re, vis_we, vis_re, vis_wdata;
    logic [AW-1:0]         mem_waddr, mem_raddr, vis_waddr, vis_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis[vis_waddr] <= vis_wdata;
        end
        if (vis_re) begin
            r_vis_q <= r_vis[vis_raddr];
        end
    end

    // walk state
    iptcf_pkg::t_state     r_state, n_state;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [AW-1:0]         r_last, n_last;
    logic [AW-1:0]         r_clr, n_clr;
    logic [AW-1:0]         r_cs, n_cs;        // cycle start
    logic [AW-1:0]         r_wp, n_wp;        // walk position
    logic [DATA_WIDTH-1:0] r_held, n_held;    // element carried along the cycle
    logic [PW-1:0]         r_prod, n_prod;
    logic [AW-1:0]         r_rem, n_rem;
    logic [CW-1:0]         r_bit, n_bit;

    // output register
    logic r_out_valid, n_out_valid;
    logic r_out_rd, n_out_rd;
    logic r_out_err, n_out_err;

    // bit-serial modulo step
    logic [AW:0]   mod_t;
    logic [AW-1:0] mod_next;

    assign mod_t    = {r_rem, r_prod[PW-1]};
    assign mod_next = (mod_t >= {1'b0, r_last}) ? AW'(mod_t - {1'b0, r_last}) : AW'(mod_t);

    logic out_free;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == iptcf_pkg::ST_IDLE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_last      = r_last;
        n_clr       = r_clr;
        n_cs        = r_cs;
        n_wp        = r_wp;
        n_held      = r_held;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_rd    = r_out_rd;
        n_out_err   = r_out_err;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_wp;
        mem_raddr = r_cs;
        mem_wdata = r_held;
        vis_we    = 1'b0;
        vis_re    = 1'b0;
        vis_waddr = r_wp;
        vis_raddr = r_cs;
        vis_wdata = 1'b1;

        unique case (r_state)
            iptcf_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_func)
                        iptcf_pkg::FUNC_WRITE: begin
                            mem_we      = in_range;
                            mem_waddr   = in_addr;
                            mem_wdata   = in_value64[DATA_WIDTH-1:0];
                            n_out_valid = 1'b1;
                            n_out_rd    = 1'b0;
                            n_out_err   = 1'b0;
                        end
                        iptcf_pkg::FUNC_READ: begin
                            mem_re      = in_range;
                            mem_raddr   = in_addr;
                            n_out_valid = 1'b1;
                            n_out_rd    = in_range;
                            n_out_err   = 1'b0;
                        end
                        iptcf_pkg::FUNC_TRANSPOSE: begin
                            n_size  = SIZE_W'(r_rows) * SIZE_W'(r_cols);
                            n_state = iptcf_pkg::ST_CHECK;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_rd    = 1'b0;
                            n_out_err   = 1'b0;
                        end
                    endcase
                end
            end
            iptcf_pkg::ST_CHECK: begin
                n_last = AW'(r_size - SIZE_W'(1));
                n_clr  = '0;
                if (32'(r_size) > 32'(MAX_ELEMENTS) || r_size < SIZE_W'(2)) begin
                    // too large or trivial: no data moves
                    n_out_valid = 1'b1;
                    n_out_rd    = 1'b0;
                    n_out_err   = 32'(r_size) > 32'(MAX_ELEMENTS);
                    n_state     = iptcf_pkg::ST_IDLE;
                end else begin
                    n_state = iptcf_pkg::ST_CLEAR;
                end
            end
            iptcf_pkg::ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = r_clr;
                vis_wdata = 1'b0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == r_last - AW'(1)) begin
                    n_cs    = AW'(1);
                    n_state = iptcf_pkg::ST_SCAN;
                end
            end
            iptcf_pkg::ST_SCAN: begin
                if (r_cs == r_last) begin
                    // the last element is fixed
                    n_out_valid = 1'b1;
                    n_out_rd    = 1'b0;
                    n_out_err   = 1'b0;
                    n_state     = iptcf_pkg::ST_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    vis_re  = 1'b1;
                    n_state = iptcf_pkg::ST_TEST;
                end
            end
            iptcf_pkg::ST_TEST: begin
                if (r_vis_q) begin
                    n_cs    = r_cs + AW'(1);
                    n_state = iptcf_pkg::ST_SCAN;
                end else begin
                    n_held  = r_mem_q;
                    n_wp    = r_cs;
                    n_state = iptcf_pkg::ST_MUL;
                end
            end
            iptcf_pkg::ST_MUL: begin
                n_prod  = PW'(r_rows) * PW'(r_wp);
                n_rem   = '0;
                n_bit   = CW'(PW - 1);
                n_state = iptcf_pkg::ST_MOD;
            end
            iptcf_pkg::ST_MOD: begin
                n_rem  = mod_next;
                n_prod = r_prod << 1;
                n_bit  = r_bit - CW'(1);
                if (r_bit == '0) begin
                    n_wp    = mod_next;
                    n_state = iptcf_pkg::ST_STEP;
                end
            end
            iptcf_pkg::ST_STEP: begin
                if (r_wp == r_cs) begin
                    // cycle closed: carried element lands at the start
                    mem_we    = 1'b1;
                    mem_waddr = r_cs;
                    vis_we    = 1'b1;
                    vis_waddr = r_cs;
                    n_cs      = r_cs + AW'(1);
                    n_state   = iptcf_pkg::ST_SCAN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_wp;
                    vis_we    = 1'b1;
                    n_state   = iptcf_pkg::ST_SWAP;
                end
            end
            iptcf_pkg::ST_SWAP: begin
                mem_we  = 1'b1;
                n_held  = r_mem_q;
                n_state = iptcf_pkg::ST_MUL;
            end
            default: n_state = iptcf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iptcf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_last    <= n_last;
        r_clr     <= n_clr;
        r_cs      <= n_cs;
        r_wp      <= n_wp;
        r_held    <= n_held;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_bit     <= n_bit;
        r_out_rd  <= n_out_rd;
        r_out_err <= n_out_err;
    end

    // read data sized to the 32-bit result field
    logic [63:0] rd64;
    assign rd64 = 64'(r_mem_q);

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_rd ? rd64[31:0] : 32'd0;
    assign o_m_tuser[0] = r_out_err;

    // a non-transpose transaction yields its result on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_func != iptcf_pkg::FUNC_TRANSPOSE |=> o_m_tvalid)
        else $error("element transaction gave no result");

    // a transpose leaves the idle state
    a_transpose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_func == iptcf_pkg::FUNC_TRANSPOSE |=> !o_s_tready && !o_m_tvalid)
        else $error("transpose did not occupy the block");

    // walk position stays below the fixed last element
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == iptcf_pkg::ST_STEP |-> r_wp < r_last && r_cs < r_last)
        else $error("walk position out of range");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the in-place cycle-following transpose unit
// ----------------------------------------------------------------------------
// element writes, reads, unused codes and transposes stream in through the
// command port; a scoreboard keeps its own copy of the store and of a
// written-entry map, permutes both on every transpose, and checks each
// result transaction in order; both stream sides idle at random per phase
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [31:0] rd;
        logic        err;
    } t_result;

    class transpose_scoreboard;
        logic [31:0] elem_mem [0:1023];
        bit          written [0:1023];
        bit          seen [0:1023];
        int          rows;
        int          cols;
        t_result     pending_q [$];

        function void init();
            rows = 1;
            cols = 1;
            for (int i = 0; i < 1024; i++) begin
                elem_mem[i] = '0;
                written[i]  = 1'b0;
            end
        endfunction

        // cycle-following permutation of data and written map together
        function bit permute();
            int          total;
            int          last;
            int          pos;
            logic [31:0] held;
            bit          wheld;
            total = rows * cols;
            if (total > 1024) return 1'b1;
            if (total < 2) return 1'b0;
            last = total - 1;
            for (int i = 0; i < 1024; i++) seen[i] = 1'b0;
            for (int start = 1; start < total; start++) begin
                if (!seen[start]) begin
                    pos = start;
                    do begin
                        if (pos != last) pos = (rows * pos) % last;
                        held          = elem_mem[pos];
                        wheld         = written[pos];
                        elem_mem[pos] = elem_mem[start];
                        written[pos]  = written[start];
                        elem_mem[start] = held;
                        written[start]  = wheld;
                        seen[pos] = 1'b1;
                    end while (pos != start);
                end
            end
            return 1'b0;
        endfunction

        function void note(iptcf_pkg::t_func f, logic [9:0] idx, logic [31:0] val);
            t_result r;
            r = '0;
            case (f)
                iptcf_pkg::FUNC_WRITE: begin
                    elem_mem[idx] = val;
                    written[idx]  = 1'b1;
                end
                iptcf_pkg::FUNC_READ:      r.rd  = elem_mem[idx];
                iptcf_pkg::FUNC_TRANSPOSE: r.err = permute();
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        // returns 0 on match; msg holds the reason otherwise
        function bit check(logic [31:0] rd, logic err, output string msg);
            t_result e;
            if (pending_q.size() == 0) begin
                msg = $sformatf("unexpected result rd=%h err=%0b", rd, err);
                return 1'b1;
            end
            e = pending_q.pop_front();
            if (e.rd !== rd || e.err !== err) begin
                msg = $sformatf("result rd=%h err=%0b, wanted rd=%h err=%0b",
                                rd, err, e.rd, e.err);
                return 1'b1;
            end
            msg = "";
            return 1'b0;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_addr;
    logic [10:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    transpose_scoreboard sb;
    int err_count;
    int idle_pct;
    int stall_pct;

    in_place_transpose_cycle_follow_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr  = iptcf_pkg::REG_ROW_COUNT;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = iptcf_pkg::FUNC_NOP;
        i_m_tready  = 1'b0;
    end

    // result side: random back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // check every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sb.check(o_m_tdata, o_m_tuser[0], msg)) report(msg);
        end
    end

    task automatic send(input iptcf_pkg::t_func f, input logic [9:0] idx,
                        input logic [31:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f;
        i_s_tdata  <= {6'd0, val, idx};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note(f, idx, val);
    endtask

    // wait for all expected results, then a settling pause
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_reg(input iptcf_pkg::t_reg_idx a, input int v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_data  <= v[10:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (a == iptcf_pkg::REG_ROW_COUNT) sb.rows = v;
        else sb.cols = v;
    endtask

    task automatic set_shape(input int r, input int c);
        set_reg(iptcf_pkg::REG_ROW_COUNT, r);
        set_reg(iptcf_pkg::REG_COL_COUNT, c);
    endtask

    // read a written entry near a random spot, or write if none exists
    task automatic read_some(input int span);
        int start;
        int k;
        start = $urandom_range(0, span - 1);
        for (k = 0; k < 1024; k++) begin
            if (sb.written[(start + k) % 1024]) break;
        end
        if (k == 1024) send(iptcf_pkg::FUNC_WRITE, start[9:0], $urandom);
        else send(iptcf_pkg::FUNC_READ, 10'((start + k) % 1024), $urandom);
    endtask

    // random phase: mostly in-shape writes and reads, some transposes and nops
    task automatic run_phase(input int n);
        int r;
        int span;
        int rr;
        int cc;
        for (int i = 0; i < n; i++) begin
            span = sb.rows * sb.cols;
            if (span > 1024 || span < 2 || $urandom_range(0, 9) == 0) span = 1024;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send(iptcf_pkg::FUNC_WRITE, 10'($urandom_range(0, span - 1)), $urandom);
            end else if (r < 86) begin
                read_some(span);
            end else if (r < 94) begin
                send(iptcf_pkg::FUNC_TRANSPOSE, 10'($urandom), $urandom);
                // pause until the transpose result is in, then reshape
                drain();
                if ($urandom_range(0, 3) == 0) begin
                    rr = $urandom_range(1, 12);
                    cc = $urandom_range(1, 12);
                    if ($urandom_range(0, 9) == 0) cc = $urandom_range(13, 40);
                    set_shape(rr, cc);
                end else begin
                    set_shape(sb.cols, sb.rows);
                end
            end else begin
                send(iptcf_pkg::FUNC_NOP, 10'($urandom), $urandom);
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        sb.init();
        err_count = 0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every code, degenerate and oversize shapes
        send(iptcf_pkg::FUNC_WRITE, 10'd0, 32'h0000_0000);
        send(iptcf_pkg::FUNC_WRITE, 10'd1023, 32'hFFFF_FFFF);
        send(iptcf_pkg::FUNC_WRITE, 10'd1, 32'hA5A5_5A5A);
        send(iptcf_pkg::FUNC_READ, 10'd0, 32'hFFFF_FFFF);
        send(iptcf_pkg::FUNC_READ, 10'd1023, 32'h0);
        send(iptcf_pkg::FUNC_NOP, 10'd1023, 32'hFFFF_FFFF);
        send(iptcf_pkg::FUNC_TRANSPOSE, 10'd0, 32'h0);        // size one, no effect
        send(iptcf_pkg::FUNC_READ, 10'd1, 32'h0);
        drain();
        set_shape(1024, 1024);
        send(iptcf_pkg::FUNC_TRANSPOSE, 10'd0, 32'h0);        // oversize
        send(iptcf_pkg::FUNC_READ, 10'd1023, 32'h0);
        drain();
        set_shape(33, 32);
        send(iptcf_pkg::FUNC_TRANSPOSE, 10'd0, 32'h0);        // just over the store
        drain();
        set_shape(2, 3);
        for (int i = 0; i < 6; i++) send(iptcf_pkg::FUNC_WRITE, 10'(i), 32'h100 + i);
        send(iptcf_pkg::FUNC_TRANSPOSE, 10'd0, 32'h0);
        for (int i = 0; i < 6; i++) send(iptcf_pkg::FUNC_READ, 10'(i), 32'h0);
        drain();
        set_shape(1024, 1);                        // full store, sparse data
        send(iptcf_pkg::FUNC_TRANSPOSE, 10'd0, 32'h0);
        send(iptcf_pkg::FUNC_READ, 10'd1023, 32'h0);
        drain();
        set_shape(1, 1024);
        send(iptcf_pkg::FUNC_TRANSPOSE, 10'd0, 32'h0);
        send(iptcf_pkg::FUNC_READ, 10'd0, 32'h0);
        drain();

        set_shape(4, 5);
        idle_pct = 0;  stall_pct = 0;  run_phase(275);
        set_shape(7, 3);
        idle_pct = 59; stall_pct = 0;  run_phase(275);
        set_shape(1, 9);
        idle_pct = 0;  stall_pct = 59; run_phase(275);
        set_shape(8, 8);
        idle_pct = 36; stall_pct = 36; run_phase(275);

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule
